// ----- sv/ssp_pkg.sv -----
package ssp_pkg;

  // Channel count and the index width that follows from it.
  localparam int CHANNELS = 5;
  localparam int CH_W     = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  // Fixed field widths.
  localparam int MASK_W   = 5;
  localparam int CHF_W    = 3;
  localparam int TGT_W    = 12;
  localparam int STEP_W   = 12;
  localparam int PHASE_W  = 4;
  localparam int POS_W    = 18;
  localparam int ERR_W    = 19;
  localparam int PWM_W    = 12;
  localparam int QMAG_W   = 11;
  localparam int PMAG_W   = 17;

  // Configuration register indexes.
  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_SPAN   = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CENTER = 1'd1;

  localparam logic [PWM_W-1:0] SPAN_RESET   = 12'd800;
  localparam logic [PWM_W-1:0] CENTER_RESET = 12'd2040;

  // Target saturation limits.
  localparam logic signed [TGT_W-1:0] TGT_MIN = -12'sd1024;
  localparam logic signed [TGT_W-1:0] TGT_MAX = 12'sd1024;

  // Positions are kept in hundredths of a position unit.
  localparam logic signed [ERR_W-1:0] SCALE = 19'sd100;

  // Division by 100 as a multiply by a reciprocal; exact for 17-bit magnitudes.
  localparam int RECIP_W     = 24;
  localparam int RECIP_SHIFT = 30;
  localparam int DPROD_W     = PMAG_W + RECIP_W;
  localparam logic [RECIP_W-1:0] RECIP100 = 24'd10737419;

  // Span scaling: (q * span / 2) / 512 is one truncating division by 1024.
  localparam int SPROD_W    = QMAG_W + PWM_W;
  localparam int SPAN_SHIFT = 10;
  localparam int PM_W       = SPROD_W - SPAN_SHIFT;
  localparam int W_W        = 15;

  localparam logic signed [W_W-1:0] WIDTH_MIN = 15'sd200;
  localparam logic signed [W_W-1:0] WIDTH_MAX = 15'sd3250;

  // Item kinds.
  localparam logic KIND_TICK = 1'b0;
  localparam logic KIND_SET  = 1'b1;

  typedef struct packed {
    logic                     kind;
    logic [CHF_W-1:0]         channel;
    logic signed [TGT_W-1:0]  target;
    logic [STEP_W-1:0]        speed;
    logic                     enable;
    logic [PHASE_W-1:0]       phase;
    logic [MASK_W-1:0]        pulse_levels;
  } in_item_t;

  typedef struct packed {
    logic [MASK_W-1:0]        enabled_mask;
    logic [MASK_W-1:0]        zeroed_mask;
    logic                     pwm_valid;
    logic [CHF_W-1:0]         pwm_channel;
    logic [PWM_W-1:0]         pwm_width;
  } out_item_t;

  typedef struct packed {
    logic [MASK_W-1:0]        enabled_mask;
    logic [MASK_W-1:0]        zeroed_mask;
    logic                     pwm_valid;
    logic [CHF_W-1:0]         pwm_channel;
    logic signed [POS_W-1:0]  position;
  } upd_t;

  typedef struct packed {
    logic [MASK_W-1:0]        enabled_mask;
    logic [MASK_W-1:0]        zeroed_mask;
    logic                     pwm_valid;
    logic [CHF_W-1:0]         pwm_channel;
    logic                     neg;
    logic [QMAG_W-1:0]        qmag;
  } quo_t;

endpackage

// ----- sv/ssp_stream_if.sv -----
interface ssp_in_if;
  import ssp_pkg::*;

  logic     valid;
  logic     ready;
  in_item_t item;

  modport source (output valid, output item, input ready);
  modport sink (input valid, input item, output ready);
endinterface

interface ssp_out_if;
  import ssp_pkg::*;

  logic      valid;
  logic      ready;
  out_item_t item;

  modport source (output valid, output item, input ready);
  modport sink (input valid, input item, output ready);
endinterface

// ----- sv/ssp_update.sv -----
module ssp_update (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              load,
  input  ssp_pkg::in_item_t item,
  output ssp_pkg::upd_t     upd_r
);
  import ssp_pkg::*;

  logic [CHANNELS-1:0]            enabled_r, enabled_nxt;
  logic [CHANNELS-1:0]            req_r;
  logic signed [TGT_W-1:0]        target_r [CHANNELS];
  logic [STEP_W-1:0]              step_r   [CHANNELS];
  logic signed [POS_W-1:0]        pos_r    [CHANNELS];

  logic [CHANNELS-1:0]            levels;
  logic [CHANNELS-1:0]            zeroed;
  logic [CH_W-1:0]                ch_idx;
  logic [CH_W-1:0]                ph_idx;
  logic                           ch_ok;
  logic                           ph_sel;
  logic signed [TGT_W-1:0]        tgt_sat;
  logic signed [ERR_W-1:0]        err;
  logic signed [ERR_W-1:0]        mag;
  logic signed [ERR_W-1:0]        lim;
  logic signed [ERR_W-1:0]        dw;
  logic signed [POS_W-1:0]        pos_new;
  logic                           move;
  upd_t                           upd_nxt;

  always_comb begin
    ch_idx = CH_W'(item.channel);
    ph_idx = CH_W'(item.phase);
    ch_ok  = int'(item.channel) < CHANNELS;
    levels = CHANNELS'(item.pulse_levels);

    if (item.target < TGT_MIN) begin
      tgt_sat = TGT_MIN;
    end else if (item.target > TGT_MAX) begin
      tgt_sat = TGT_MAX;
    end else begin
      tgt_sat = item.target;
    end

    // Enable settling: switching on is immediate, switching off waits for a low pulse.
    enabled_nxt = enabled_r;
    zeroed      = '0;
    for (int i = 0; i < CHANNELS; i++) begin
      if (enabled_r[i] != req_r[i]) begin
        if (req_r[i]) begin
          enabled_nxt[i] = 1'b1;
        end else if (!levels[i]) begin
          enabled_nxt[i] = 1'b0;
          zeroed[i]      = 1'b1;
        end
      end
    end

    ph_sel = (int'(item.phase) < CHANNELS) && enabled_nxt[ph_idx];

    err = ERR_W'(target_r[ph_idx]) * SCALE - ERR_W'(pos_r[ph_idx]);
    mag = (err < 0) ? -err : err;
    lim = signed'(ERR_W'(step_r[ph_idx]));
    if ((lim != '0) && (mag > lim)) begin
      dw = (err > 0) ? lim : -lim;
    end else begin
      dw = err;
    end
    pos_new = POS_W'(ERR_W'(pos_r[ph_idx]) + dw);
    move    = ph_sel && (dw != '0);

    if (item.kind == KIND_SET) begin
      upd_nxt.enabled_mask = MASK_W'(enabled_r);
      upd_nxt.zeroed_mask  = '0;
      upd_nxt.pwm_valid    = 1'b0;
      upd_nxt.pwm_channel  = '0;
    end else begin
      upd_nxt.enabled_mask = MASK_W'(enabled_nxt);
      upd_nxt.zeroed_mask  = MASK_W'(zeroed);
      upd_nxt.pwm_valid    = move;
      upd_nxt.pwm_channel  = move ? CHF_W'(item.phase) : '0;
    end
    upd_nxt.position = pos_new;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enabled_r <= '0;
      req_r     <= '0;
      for (int i = 0; i < CHANNELS; i++) begin
        target_r[i] <= '0;
        step_r[i]   <= '0;
        pos_r[i]    <= '0;
      end
    end else if (load) begin
      if (item.kind == KIND_SET) begin
        if (ch_ok) begin
          target_r[ch_idx] <= tgt_sat;
          step_r[ch_idx]   <= item.speed;
          req_r[ch_idx]    <= item.enable;
        end
      end else begin
        enabled_r <= enabled_nxt;
        if (move) begin
          pos_r[ph_idx] <= pos_new;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      upd_r <= upd_nxt;
    end
  end

endmodule

// ----- sv/ssp_scale.sv -----
module ssp_scale (
  input  logic          clk,
  input  logic          load,
  input  ssp_pkg::upd_t upd,
  output ssp_pkg::quo_t quo_r
);
  import ssp_pkg::*;

  logic              neg;
  logic [PMAG_W-1:0] pmag;
  logic [DPROD_W-1:0] prod;
  quo_t              quo_nxt;

  // Truncating division by 100 on the magnitude, sign reapplied later.
  always_comb begin
    neg  = upd.position < 0;
    pmag = PMAG_W'(neg ? -upd.position : upd.position);
    prod = DPROD_W'(pmag) * DPROD_W'(RECIP100);

    quo_nxt.enabled_mask = upd.enabled_mask;
    quo_nxt.zeroed_mask  = upd.zeroed_mask;
    quo_nxt.pwm_valid    = upd.pwm_valid;
    quo_nxt.pwm_channel  = upd.pwm_channel;
    quo_nxt.neg          = neg;
    quo_nxt.qmag         = QMAG_W'(prod >> RECIP_SHIFT);
  end

  always_ff @(posedge clk) begin
    if (load) begin
      quo_r <= quo_nxt;
    end
  end

endmodule

// ----- sv/ssp_pulse.sv -----
module ssp_pulse (
  input  logic                          clk,
  input  logic                          load,
  input  ssp_pkg::quo_t                 quo,
  input  logic [ssp_pkg::PWM_W-1:0]     span,
  input  logic [ssp_pkg::PWM_W-1:0]     center,
  output ssp_pkg::out_item_t            out_r
);
  import ssp_pkg::*;

  logic [SPROD_W-1:0]     prod;
  logic [PM_W-1:0]        pm;
  logic signed [W_W-1:0]  w;
  logic signed [W_W-1:0]  w_clamp;
  out_item_t              out_nxt;

  always_comb begin
    prod = SPROD_W'(quo.qmag) * SPROD_W'(span);
    pm   = PM_W'(prod >> SPAN_SHIFT);
    if (quo.neg) begin
      w = signed'(W_W'(center)) - signed'(W_W'(pm));
    end else begin
      w = signed'(W_W'(center)) + signed'(W_W'(pm));
    end

    if (w < WIDTH_MIN) begin
      w_clamp = WIDTH_MIN;
    end else if (w > WIDTH_MAX) begin
      w_clamp = WIDTH_MAX;
    end else begin
      w_clamp = w;
    end

    out_nxt.enabled_mask = quo.enabled_mask;
    out_nxt.zeroed_mask  = quo.zeroed_mask;
    out_nxt.pwm_valid    = quo.pwm_valid;
    out_nxt.pwm_channel  = quo.pwm_channel;
    out_nxt.pwm_width    = quo.pwm_valid ? PWM_W'(w_clamp) : '0;
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_r <= out_nxt;
    end
  end

endmodule

// ----- sv/servo_slew_pwm_controller_unit.sv -----
// Channel   Direction  Handshake         Payload
// in_ch     sink       valid / ready     kind, channel, target, speed, enable, phase,
//                                        pulse_levels
// out_ch    source     valid / ready     enabled_mask, zeroed_mask, pwm_valid,
//                                        pwm_channel, pwm_width
// cfg_*     sink       cfg_we only       cfg_index, cfg_wdata (pulse span, pulse center)
//
// Each transaction passes four registers: input, state update, divide by 100 and
// the pulse width result. One transaction is taken per cycle unless out_ch stalls;
// every stage moves on when the next one is empty or moving, so a stalled result
// does not block items in empty earlier stages.
// Reset (rst_n low at a clock edge) clears all channel state, the stage valid flags
// and loads the span and center registers with their default values.
module servo_slew_pwm_controller_unit (
  input  logic                            clk,
  input  logic                            rst_n,
  ssp_in_if.sink                          in_ch,
  ssp_out_if.source                       out_ch,
  input  logic                            cfg_we,
  input  logic [ssp_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [ssp_pkg::PWM_W-1:0]       cfg_wdata
);
  import ssp_pkg::*;

  // Configuration registers.
  logic [PWM_W-1:0] span_r;
  logic [PWM_W-1:0] center_r;

  // Pipeline valid flags and the input register.
  logic     in_v_r;
  logic     upd_v_r;
  logic     quo_v_r;
  logic     out_v_r;
  in_item_t in_r;

  // Per-stage ready: a stage can take new data when it is empty or draining.
  logic rdy_out;
  logic rdy_quo;
  logic rdy_upd;
  logic rdy_in;

  upd_t      upd_r;
  quo_t      quo_r;
  out_item_t out_r;

  assign rdy_out = !out_v_r || out_ch.ready;
  assign rdy_quo = !quo_v_r || rdy_out;
  assign rdy_upd = !upd_v_r || rdy_quo;
  assign rdy_in  = !in_v_r  || rdy_upd;

  assign in_ch.ready  = rdy_in;
  assign out_ch.valid = out_v_r;
  assign out_ch.item  = out_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      span_r   <= SPAN_RESET;
      center_r <= CENTER_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_SPAN:   span_r   <= cfg_wdata;
        CFG_CENTER: center_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r  <= 1'b0;
      upd_v_r <= 1'b0;
      quo_v_r <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      if (rdy_in) begin
        in_v_r <= in_ch.valid;
      end
      if (rdy_upd) begin
        upd_v_r <= in_v_r;
      end
      if (rdy_quo) begin
        quo_v_r <= upd_v_r;
      end
      if (rdy_out) begin
        out_v_r <= quo_v_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && rdy_in) begin
      in_r <= in_ch.item;
    end
  end

  // Channel state lives here; it is read and written only when an item enters this
  // stage, so back-to-back items always see the state left by the one before.
  ssp_update u_update (
    .clk   (clk),
    .rst_n (rst_n),
    .load  (in_v_r && rdy_upd),
    .item  (in_r),
    .upd_r (upd_r)
  );

  ssp_scale u_scale (
    .clk   (clk),
    .load  (upd_v_r && rdy_quo),
    .upd   (upd_r),
    .quo_r (quo_r)
  );

  // The user must change span and center only while idle; it is not enforced.
  ssp_pulse u_pulse (
    .clk    (clk),
    .load   (quo_v_r && rdy_out),
    .quo    (quo_r),
    .span   (span_r),
    .center (center_r),
    .out_r  (out_r)
  );

endmodule

// ----- test/servo_slew_pwm_controller_unit_test.sv -----
module servo_slew_pwm_controller_unit_test;
  import ssp_pkg::*;

  localparam int ITEMS_PER_PHASE = 290;
  localparam int NUM_PHASES      = 6;
  localparam int HOLD_CYCLES     = 300;
  localparam int DRAIN_LIMIT     = 2000;
  localparam int SETTLE_CYCLES   = 8;
  localparam int TIMEOUT_CYCLES  = 400000;

  // Tracks the servo channels the way the block should, and keeps the results that
  // accepted transactions are still owed, oldest first.
  class slew_pwm_tracker;
    logic [PWM_W-1:0] span;
    logic [PWM_W-1:0] center;
    bit               enabled [CHANNELS];
    bit               enable_req [CHANNELS];
    int               target_pos [CHANNELS];
    int               step_limit [CHANNELS];
    int               position [CHANNELS];
    out_item_t        expected_results [$];
    int               errors;
    int               checked;
    int               pwm_writes;
    int               forced_zero;

    function new();
      span        = SPAN_RESET;
      center      = CENTER_RESET;
      errors      = 0;
      checked     = 0;
      pwm_writes  = 0;
      forced_zero = 0;
    endfunction

    function void set_register(logic [CFG_IDX_W-1:0] idx, logic [PWM_W-1:0] val);
      if (idx == CFG_SPAN) begin
        span = val;
      end else begin
        center = val;
      end
    endfunction

    function void predict_item(in_item_t it);
      out_item_t r;
      int        t;
      int        err;
      int        mag;
      int        dw;
      int        w;
      r = '0;
      if (it.kind == KIND_SET) begin
        if (it.channel < CHANNELS) begin
          t = it.target;
          if (t < -1024) begin
            t = -1024;
          end else if (t > 1024) begin
            t = 1024;
          end
          target_pos[it.channel] = t;
          step_limit[it.channel] = it.speed;
          enable_req[it.channel] = it.enable;
        end
      end else begin
        // A channel switches off only once its pulse reads low.
        for (int i = 0; i < CHANNELS; i++) begin
          if (enabled[i] != enable_req[i]) begin
            if (enable_req[i]) begin
              enabled[i] = 1'b1;
            end else if (!it.pulse_levels[i]) begin
              enabled[i]        = 1'b0;
              r.zeroed_mask[i]  = 1'b1;
              forced_zero++;
            end
          end
        end
        if (it.phase < CHANNELS && enabled[it.phase]) begin
          err = target_pos[it.phase] * 100 - position[it.phase];
          mag = (err < 0) ? -err : err;
          dw  = err;
          if (step_limit[it.phase] > 0 && mag > step_limit[it.phase]) begin
            dw = (err > 0) ? step_limit[it.phase] : -step_limit[it.phase];
          end
          if (dw != 0) begin
            position[it.phase] += dw;
            w = ((position[it.phase] / 100) * int'(span)) / 2 / 512 + int'(center);
            if (w < 200) begin
              w = 200;
            end else if (w > 3250) begin
              w = 3250;
            end
            r.pwm_valid   = 1'b1;
            r.pwm_channel = it.phase[CHF_W-1:0];
            r.pwm_width   = w[PWM_W-1:0];
            pwm_writes++;
          end
        end
      end
      for (int i = 0; i < CHANNELS; i++) begin
        r.enabled_mask[i] = enabled[i];
      end
      expected_results.push_back(r);
    endfunction

    function void compare_field(string name, logic [15:0] want, logic [15:0] got);
      if (got !== want) begin
        errors++;
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      end
    endfunction

    function void check_result(out_item_t got);
      out_item_t want;
      if (expected_results.size() == 0) begin
        errors++;
        $display("%0t: result with nothing outstanding, expected none, actual %h",
                 $time, got);
        return;
      end
      want = expected_results.pop_front();
      checked++;
      compare_field("enabled_mask", want.enabled_mask, got.enabled_mask);
      compare_field("zeroed_mask", want.zeroed_mask, got.zeroed_mask);
      compare_field("pwm_valid", want.pwm_valid, got.pwm_valid);
      compare_field("pwm_channel", want.pwm_channel, got.pwm_channel);
      compare_field("pwm_width", want.pwm_width, got.pwm_width);
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [PWM_W-1:0] cfg_wdata;

  ssp_in_if  in_if ();
  ssp_out_if out_if ();

  slew_pwm_tracker sb = new();

  // Idle rates of the two sides, in percent of cycles; changed between phases.
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  // Set by the stimulus to make the result side hold off for a long stretch.
  bit hold_request  = 1'b0;
  int heartbeat     = 0;
  int items_sent    = 0;

  servo_slew_pwm_controller_unit i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_if),
    .out_ch    (out_if),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always #4 clk = ~clk;

  // Every transaction on either channel is seen here at the clock edge, before any
  // driver update of that edge lands. Inputs are noted first so that the order of
  // expectations always follows the order of acceptance.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_if.valid && in_if.ready) begin
        sb.predict_item(in_if.item);
      end
      if (out_if.valid && out_if.ready) begin
        sb.check_result(out_if.item);
      end
    end
  end

  // Result side. It drops ready at random, and on request holds it low for a long
  // counted stretch so that the pipeline fills and the input side stalls.
  initial begin : result_sink
    int hold_left;
    hold_left    = 0;
    out_if.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_request) begin
        hold_request = 1'b0;
        hold_left    = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // Offers one transaction after a random gap and returns at the edge that accepts it.
  // Valid is left high, so a following call either keeps it high or drops it once.
  task automatic send_item(in_item_t it);
    while ($urandom_range(99) < send_idle_pct) begin
      in_if.valid <= 1'b0;
      @(posedge clk);
    end
    in_if.valid <= 1'b1;
    in_if.item  <= it;
    @(posedge clk);
    while (!in_if.ready) begin
      @(posedge clk);
    end
    items_sent++;
  endtask

  task automatic send_fields(logic kind, logic [CHF_W-1:0] ch, logic [TGT_W-1:0] tgt,
                             logic [STEP_W-1:0] spd, logic en, logic [PHASE_W-1:0] ph,
                             logic [MASK_W-1:0] lv);
    in_item_t it;
    it.kind         = kind;
    it.channel      = ch;
    it.target       = tgt;
    it.speed        = spd;
    it.enable       = en;
    it.phase        = ph;
    it.pulse_levels = lv;
    send_item(it);
  endtask

  // Drops valid and waits until every accepted transaction has produced its result,
  // which also means the pipeline is empty and registers may be written. The first
  // edge lets the monitor note a transaction accepted at the current edge.
  task automatic wait_drained();
    in_if.valid <= 1'b0;
    @(posedge clk);
    while (sb.expected_results.size() != 0) begin
      @(posedge clk);
    end
  endtask

  // Writes one register and leaves the write enable low afterwards.
  task automatic program_register(logic [CFG_IDX_W-1:0] idx, logic [PWM_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.set_register(idx, val);
    @(posedge clk);
  endtask

  // Mostly well-formed traffic: ticks follow the heartbeat and sets land on real
  // channels with sane targets. A minority is noise: stray phases, missing
  // channels and raw 12-bit targets. Unused fields are random so every bit toggles.
  function automatic in_item_t random_item();
    in_item_t it;
    it.kind         = ($urandom_range(99) < 25) ? KIND_SET : KIND_TICK;
    it.channel      = ($urandom_range(9) == 0) ? 3'($urandom_range(7, 5))
                                               : 3'($urandom_range(4));
    it.target       = ($urandom_range(9) == 0) ? 12'($urandom)
                                               : 12'($urandom_range(2048)) - 12'd1024;
    case ($urandom_range(3))
      0:       it.speed = '0;
      3:       it.speed = 12'($urandom);
      default: it.speed = 12'($urandom_range(600, 1));
    endcase
    it.enable       = ($urandom_range(99) < 85);
    it.pulse_levels = ($urandom_range(1) == 0) ? '0 : 5'($urandom);
    if (it.kind == KIND_TICK && $urandom_range(99) < 85) begin
      it.phase  = 4'(heartbeat);
      heartbeat = (heartbeat + 1) % 10;
    end else begin
      it.phase = 4'($urandom);
    end
    return it;
  endfunction

  initial begin : stimulus
    logic [PWM_W-1:0] span_plan [NUM_PHASES];
    logic [PWM_W-1:0] center_plan [NUM_PHASES];
    int               waited;
    rst_n        = 1'b0;
    in_if.valid  = 1'b0;
    in_if.item   = '0;
    cfg_we       = 1'b0;
    cfg_index    = CFG_SPAN;
    cfg_wdata    = '0;

    // Defaults first, then both extremes, mixed extremes and two random settings.
    span_plan   = '{12'd800, 12'd4095, 12'd0, 12'd4095, 12'd0, 12'd0};
    center_plan = '{12'd2040, 12'd4095, 12'd0, 12'd0, 12'd0, 12'd0};
    for (int p = 4; p < NUM_PHASES; p++) begin
      span_plan[p]   = 12'($urandom);
      center_plan[p] = 12'($urandom);
    end

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part, run on the reset values of span and center.
    // A tick straight after reset moves nothing.
    send_fields(KIND_TICK, 3'd0, 12'd0, 12'd0, 1'b0, 4'd0, 5'd0);
    // Full positive and full negative deflection with no step limit.
    send_fields(KIND_SET, 3'd0, 12'd1024, 12'd0, 1'b1, 4'd0, 5'd0);
    send_fields(KIND_TICK, 3'd0, 12'd0, 12'd0, 1'b0, 4'd0, 5'd0);
    send_fields(KIND_SET, 3'd1, 12'hC00, 12'd0, 1'b1, 4'd0, 5'd0);
    send_fields(KIND_TICK, 3'd0, 12'd0, 12'd0, 1'b0, 4'd1, 5'd0);
    // Targets beyond the range saturate; the largest and the smallest step limits.
    send_fields(KIND_SET, 3'd2, 12'h7FF, 12'hFFF, 1'b1, 4'd0, 5'd0);
    send_fields(KIND_TICK, 3'd0, 12'd0, 12'd0, 1'b0, 4'd2, 5'd0);
    send_fields(KIND_SET, 3'd3, 12'h800, 12'd1, 1'b1, 4'd0, 5'd0);
    send_fields(KIND_TICK, 3'd0, 12'd0, 12'd0, 1'b0, 4'd3, 5'd0);
    // Position already at target gives no pulse width write.
    send_fields(KIND_SET, 3'd4, 12'd0, 12'd50, 1'b1, 4'd0, 5'd0);
    send_fields(KIND_TICK, 3'd0, 12'd0, 12'd0, 1'b0, 4'd4, 5'd0);
    // Sets to channels that do not exist are dropped.
    send_fields(KIND_SET, 3'd7, 12'd5, 12'd0, 1'b1, 4'hF, 5'h1F);
    send_fields(KIND_SET, 3'd5, 12'd5, 12'd0, 1'b1, 4'd0, 5'd0);
    // Phases with no channel behind them, including the top of the field.
    send_fields(KIND_TICK, 3'd7, 12'hFFF, 12'hFFF, 1'b1, 4'hF, 5'd0);
    send_fields(KIND_TICK, 3'd0, 12'd0, 12'd0, 1'b0, 4'd10, 5'd0);
    send_fields(KIND_TICK, 3'd0, 12'd0, 12'd0, 1'b0, 4'd0, 5'd0);
    // Switching off while the pulse is high keeps the channel enabled and moving;
    // a later tick with the pulse low disables it and forces its output to zero.
    send_fields(KIND_SET, 3'd0, 12'd500, 12'd0, 1'b0, 4'd0, 5'd0);
    send_fields(KIND_TICK, 3'd0, 12'd0, 12'd0, 1'b0, 4'd0, 5'h1F);
    send_fields(KIND_TICK, 3'd0, 12'd0, 12'd0, 1'b0, 4'd9, 5'd0);
    // Two channels asked off at once, only one of them with its pulse low.
    send_fields(KIND_SET, 3'd1, 12'd0, 12'd0, 1'b0, 4'd0, 5'd0);
    send_fields(KIND_SET, 3'd2, 12'd0, 12'd0, 1'b0, 4'd0, 5'd0);
    send_fields(KIND_TICK, 3'd0, 12'd0, 12'd0, 1'b0, 4'd2, 5'b00100);
    send_fields(KIND_TICK, 3'd0, 12'd0, 12'd0, 1'b0, 4'd3, 5'd0);

    // Random part, one register setting per phase. The receiver idles more in the
    // first third, the sender in the second, and neither in the last, where the
    // receiver also holds off for a long stretch once.
    for (int p = 0; p < NUM_PHASES; p++) begin
      wait_drained();
      program_register(CFG_SPAN, span_plan[p]);
      program_register(CFG_CENTER, center_plan[p]);
      send_idle_pct = (p < 2) ? 34 : (p < 4) ? 68 : 0;
      recv_idle_pct = (p < 2) ? 68 : (p < 4) ? 34 : 0;
      if (p == 4) begin
        hold_request = 1'b1;
      end
      repeat (ITEMS_PER_PHASE) begin
        send_item(random_item());
      end
    end

    // Let the last results come out, then wait out SETTLE_CYCLES, in which any
    // stray result would still be caught.
    in_if.valid <= 1'b0;
    waited = 0;
    while (sb.expected_results.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (sb.expected_results.size() != 0) begin
      sb.errors += sb.expected_results.size();
      $display("%0t: %0d results never arrived", $time, sb.expected_results.size());
    end

    $display("Run covered %0d input transactions over %0d register settings, %0d results.",
             items_sent, NUM_PHASES + 1, sb.checked);
    $display("Pulse width writes: %0d, channels forced to zero: %0d, mismatches: %0d.",
             sb.pwm_writes, sb.forced_zero, sb.errors);
    if (sb.errors == 0) begin
      $display("servo_slew_pwm_controller_unit_test: clean");
    end else begin
      $display("servo_slew_pwm_controller_unit_test: errors");
    end
    $finish;
  end

  // Hard stop in case a handshake never completes.
  initial begin : watchdog
    #(TIMEOUT_CYCLES * 8);
    $display("servo_slew_pwm_controller_unit_test: errors");
    $finish;
  end

endmodule
